FILE: rtl/core/glyph_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// Glyph frame receiver assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef GLYPH_FRAME_RECEIVER_MACROS_SVH
`define GLYPH_FRAME_RECEIVER_MACROS_SVH

// Implication checked in the same cycle.
`define GFR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the next cycle.
`define GFR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/gfr_pkg.sv
// ----------------------------------------------------------------------------
// Glyph frame receiver package
// Types and constants shared by the receiver, its parser and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gfr_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 17;

   // Result beat layout on tdata, lowest bit first.
   localparam int ECHO_LSB    = 0;
   localparam int OFFSET_LSB  = ECHO_LSB + BYTE_W;
   localparam int FRAME_LSB   = OFFSET_LSB + LEN_W;
   localparam int GLYPH_LSB   = FRAME_LSB + LEN_W;
   localparam int RSP_USED_W  = GLYPH_LSB + BYTE_W;
   localparam int RSP_TDATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_USED_W;

   localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'hC9;
   localparam logic [BYTE_W-1:0] CMD_COUNT = 8'hCA;
   localparam logic [BYTE_W-1:0] CMD_SIZE  = 8'hCB;

   localparam logic [BYTE_W-1:0] SIZE_AUTO  = 8'd0;
   localparam logic [BYTE_W-1:0] SIZE_SMALL = 8'd1;
   localparam logic [BYTE_W-1:0] SIZE_MID   = 8'd2;
   localparam logic [BYTE_W-1:0] SIZE_LARGE = 8'd3;

   localparam logic [BYTE_W-1:0] SMALL_MIN_COUNT = 8'd11;
   localparam logic [BYTE_W-1:0] MID_MIN_COUNT   = 8'd3;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_CMD   = 3'd1,
      PH_COUNT = 3'd2,
      PH_SIZE  = 3'd3,
      PH_DATA  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CTRL   = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_LAST   = 2'd2,
      KIND_REJECT = 2'd3
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] glyph_count;
      logic [LEN_W-1:0]  frame_bytes;
      logic [LEN_W-1:0]  payload_offset;
      logic [BYTE_W-1:0] echo_byte;
      kind_type          byte_kind;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/core/glyph_frame_receiver.sv
// ----------------------------------------------------------------------------
// Glyph frame receiver
// Parses glyph frames from a received byte stream and echoes every byte.
// ----------------------------------------------------------------------------
// Each received byte yields exactly one result beat that echoes it and tells
// whether it was a control byte, a payload byte, the last payload byte or the
// count byte of a rejected frame, along with the payload offset, the frame
// length and the glyph count. A byte is taken in every cycle unless input is
// stalled. An accepted byte is held in the input register, is parsed out of
// it and lands in the result register once that register is free; its
// result beat is presented from there. The result register frees as its
// beat is taken, so input is stalled only while both registers hold beats
// and the result beat is not being taken. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module glyph_frame_receiver (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] echo_byte, [24:8] payload_offset, [41:25] frame_bytes,
   // [49:42] glyph_count, [55:50] zero
   output logic [gfr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [1:0]       rsp_tuser    // [1:0] byte_kind
);

   import gfr_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff;
   rsp_type           result;
   logic              out_free;
   logic              advance;
   logic              accept;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   gfr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.byte_kind;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_ff.glyph_count, out_ff.frame_bytes,
                        out_ff.payload_offset, out_ff.echo_byte};

endmodule

`default_nettype wire

FILE: rtl/core/gfr_parser.sv
// ----------------------------------------------------------------------------
// Glyph frame parser
// Frame state registers and the per-byte decode that turns one received
// byte into one result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gfr_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire logic [gfr_pkg::BYTE_W-1:0] rx_byte,
   output gfr_pkg::rsp_type            result
);

   import gfr_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [BYTE_W-1:0]  size_ff, size_in;
   logic [BYTE_W-1:0]  glyphs_ff, glyphs_in;
   logic [LEN_W-1:0]   total_ff, total_in;
   logic [LEN_W-1:0]   position_ff, position_in;

   logic [LEN_W-1:0]   position_inc;
   logic [LEN_W-1:0]   length_small;
   logic [LEN_W-1:0]   length_mid;
   logic [LEN_W-1:0]   length_large;
   logic [LEN_W-1:0]   length;
   logic               size_bad;
   logic               reject;
   logic               last;

   assign position_inc = position_ff + LEN_W'(1);
   assign last         = (position_inc >= total_ff);

   // Glyph sizes are powers of two, so the length is the count shifted.
   assign length_small = {{(LEN_W-BYTE_W-5){1'b0}}, rx_byte, 5'd0};
   assign length_mid   = {{(LEN_W-BYTE_W-7){1'b0}}, rx_byte, 7'd0};
   assign length_large = {rx_byte, 9'd0};

   always_comb begin
      size_bad = 1'b0;
      case (size_ff)
         SIZE_AUTO: begin
            if (rx_byte >= SMALL_MIN_COUNT) begin
               length = length_small;
            end else if (rx_byte >= MID_MIN_COUNT) begin
               length = length_mid;
            end else begin
               length = length_large;
            end
         end
         SIZE_SMALL: length = length_small;
         SIZE_MID:   length = length_mid;
         SIZE_LARGE: length = length_large;
         default: begin
            length   = '0;
            size_bad = 1'b1;
         end
      endcase
   end

   assign reject = (phase_ff == PH_COUNT) && ((rx_byte == '0) || size_bad);

   // Next phase.
   always_comb begin
      case (phase_ff)
         PH_IDLE:  phase_in = (rx_byte == HDR_BYTE) ? PH_CMD : PH_IDLE;
         PH_CMD: begin
            if (rx_byte == CMD_COUNT) begin
               phase_in = PH_COUNT;
            end else if (rx_byte == CMD_SIZE) begin
               phase_in = PH_SIZE;
            end else begin
               phase_in = PH_CMD;
            end
         end
         PH_COUNT: phase_in = reject ? PH_IDLE : PH_DATA;
         PH_SIZE:  phase_in = PH_CMD;
         PH_DATA:  phase_in = last ? PH_IDLE : PH_DATA;
         default:  phase_in = PH_CMD;
      endcase
   end

   // Frame registers and the result beat.
   always_comb begin
      size_in     = size_ff;
      glyphs_in   = glyphs_ff;
      total_in    = total_ff;
      position_in = position_ff;
      result.byte_kind      = KIND_CTRL;
      result.payload_offset = '0;
      case (phase_ff)
         PH_IDLE: begin
            size_in     = '0;
            glyphs_in   = '0;
            total_in    = '0;
            position_in = '0;
         end
         PH_COUNT: begin
            glyphs_in = rx_byte;
            if (reject) begin
               result.byte_kind = KIND_REJECT;
            end else begin
               total_in    = length;
               position_in = '0;
            end
         end
         PH_SIZE: size_in = rx_byte;
         PH_DATA: begin
            position_in           = position_inc;
            result.payload_offset = position_ff;
            result.byte_kind      = last ? KIND_LAST : KIND_DATA;
         end
         default: begin
         end
      endcase
      result.echo_byte   = rx_byte;
      result.frame_bytes = reject ? '0 : total_in;
      result.glyph_count = glyphs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         size_ff     <= '0;
         glyphs_ff   <= '0;
         total_ff    <= '0;
         position_ff <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         size_ff     <= size_in;
         glyphs_ff   <= glyphs_in;
         total_ff    <= total_in;
         position_ff <= position_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/gfr_checker.sv
// ----------------------------------------------------------------------------
// Glyph frame receiver checker
// Port-level assertions on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "glyph_frame_receiver_macros.svh"

module gfr_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [gfr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser
);

   import gfr_pkg::*;

   logic [LEN_W-1:0] offset;
   logic [LEN_W-1:0] frame_len;
   logic             is_payload;

   assign offset     = rsp_tdata[OFFSET_LSB +: LEN_W];
   assign frame_len  = rsp_tdata[FRAME_LSB +: LEN_W];
   assign is_payload = (rsp_tuser == KIND_DATA) || (rsp_tuser == KIND_LAST);

   // A stalled result beat must hold still.
   `GFR_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result beat changed while stalled")

   `GFR_ASSERT_NOW(a_offset_range, rsp_tvalid && is_payload,
      offset < frame_len, "payload offset beyond frame length")

   `GFR_ASSERT_NOW(a_last_offset, rsp_tvalid && (rsp_tuser == KIND_LAST),
      offset == (frame_len - LEN_W'(1)), "last payload beat not at end of frame")

   `GFR_ASSERT_NOW(a_reject_zero, rsp_tvalid && (rsp_tuser == KIND_REJECT),
      (offset == '0) && (frame_len == '0), "rejected frame reports nonzero length")

   `GFR_ASSERT_NOW(a_ctrl_offset, rsp_tvalid && (rsp_tuser == KIND_CTRL),
      offset == '0, "control beat carries a payload offset")

endmodule

bind glyph_frame_receiver gfr_checker u_gfr_checker (.*);

`default_nettype wire

FILE: verif/tb_glyph_frame_receiver.sv
// ----------------------------------------------------------------------------
// Glyph frame receiver testbench
// Streams received bytes into the receiver and checks every result beat,
// field by field, against a cycle-free model of the frame parser. Directed
// frames cover rejects and size boundaries; random frames, truncated frames
// and noise follow with random idling on both sides; the largest frame last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_glyph_frame_receiver;
   import gfr_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 80;
   localparam int RANDOM_ITEMS   = 400;
   localparam int MAX_REPORTS    = 40;
   // The largest frame is opened and only its first payload bytes are sent.
   localparam int LARGEST_DROP   = 512 * 255 - 16;

   localparam logic [LEN_W-1:0] GLYPH_SMALL_BYTES = 17'd32;
   localparam logic [LEN_W-1:0] GLYPH_MID_BYTES   = 17'd128;
   localparam logic [LEN_W-1:0] GLYPH_LARGE_BYTES = 17'd512;

   localparam logic [BYTE_W-1:0] CMD_UNUSED_A = 8'hCC;
   localparam logic [BYTE_W-1:0] CMD_UNUSED_B = 8'hCD;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = 8'h00;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;

   glyph_frame_receiver u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Bytes waiting to be sent and echo beats still owed by the block.
   logic [7:0] rx_q[$];
   rsp_type    echo_q[$];

   // Parser state of the model.
   phase_type        parse_ph    = PH_IDLE;
   logic [7:0]       size_sel    = '0;
   logic [7:0]       glyphs      = '0;
   logic [LEN_W-1:0] frame_total = '0;
   logic [LEN_W-1:0] frame_pos   = '0;

   int req_beats    = 0;
   int rsp_beats    = 0;
   int fail_count   = 0;
   int frame_items  = 0;
   int calm_from    = 1 << 30;
   int hold_left    = 0;
   bit hold_done    = 1'b0;
   int stall_cycles = 0;

   wire no_idle = (req_beats >= calm_from) && (req_beats < calm_from + 600);

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [LEN_W-1:0] bytes_per_glyph(input logic [7:0] size,
                                                       input logic [7:0] count);
      case (size)
         SIZE_AUTO: begin
            if (count >= SMALL_MIN_COUNT) bytes_per_glyph = GLYPH_SMALL_BYTES;
            else if (count >= MID_MIN_COUNT) bytes_per_glyph = GLYPH_MID_BYTES;
            else bytes_per_glyph = GLYPH_LARGE_BYTES;
         end
         SIZE_SMALL: bytes_per_glyph = GLYPH_SMALL_BYTES;
         SIZE_MID:   bytes_per_glyph = GLYPH_MID_BYTES;
         SIZE_LARGE: bytes_per_glyph = GLYPH_LARGE_BYTES;
         default:    bytes_per_glyph = '0;
      endcase
   endfunction

   // Advances the parser model by one byte and queues the echo it owes.
   task automatic predict_echo(input logic [7:0] b);
      rsp_type          r;
      logic [LEN_W-1:0] per;
      r.echo_byte      = b;
      r.byte_kind      = KIND_CTRL;
      r.payload_offset = '0;
      case (parse_ph)
         PH_IDLE: begin
            size_sel    = '0;
            glyphs      = '0;
            frame_total = '0;
            frame_pos   = '0;
            if (b == HDR_BYTE) parse_ph = PH_CMD;
         end
         PH_CMD: begin
            if (b == CMD_COUNT) parse_ph = PH_COUNT;
            else if (b == CMD_SIZE) parse_ph = PH_SIZE;
         end
         PH_COUNT: begin
            glyphs = b;
            per    = bytes_per_glyph(size_sel, b);
            if (b == 8'd0 || per == '0) begin
               r.byte_kind = KIND_REJECT;
               parse_ph    = PH_IDLE;
            end else begin
               frame_total = per * b;
               frame_pos   = '0;
               parse_ph    = PH_DATA;
            end
         end
         PH_SIZE: begin
            size_sel = b;
            parse_ph = PH_CMD;
         end
         PH_DATA: begin
            r.payload_offset = frame_pos;
            frame_pos        = frame_pos + 1'b1;
            if (frame_pos >= frame_total) begin
               r.byte_kind = KIND_LAST;
               parse_ph    = PH_IDLE;
            end else begin
               r.byte_kind = KIND_DATA;
            end
         end
         default: parse_ph = PH_CMD;
      endcase
      r.frame_bytes = (r.byte_kind == KIND_REJECT) ? '0 : frame_total;
      r.glyph_count = glyphs;
      echo_q.push_back(r);
   endtask

   task automatic report_mismatch(input string field, input longint got, input longint want);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("mismatch on result beat %0d: %s got 0x%0h, expected 0x%0h",
                  rsp_beats, field, got, want);
   endtask

   task automatic check_echo(input logic [RSP_TDATA_W-1:0] d, input logic [1:0] u);
      rsp_type w;
      if (echo_q.size() == 0) begin
         report_mismatch("unexpected beat, echo", d[ECHO_LSB +: BYTE_W], 0);
      end else begin
         w = echo_q.pop_front();
         if (d[ECHO_LSB +: BYTE_W] !== w.echo_byte)
            report_mismatch("echo_byte", d[ECHO_LSB +: BYTE_W], w.echo_byte);
         if (u !== w.byte_kind)
            report_mismatch("byte_kind", u, w.byte_kind);
         if (d[OFFSET_LSB +: LEN_W] !== w.payload_offset)
            report_mismatch("payload_offset", d[OFFSET_LSB +: LEN_W], w.payload_offset);
         if (d[FRAME_LSB +: LEN_W] !== w.frame_bytes)
            report_mismatch("frame_bytes", d[FRAME_LSB +: LEN_W], w.frame_bytes);
         if (d[GLYPH_LSB +: BYTE_W] !== w.glyph_count)
            report_mismatch("glyph_count", d[GLYPH_LSB +: BYTE_W], w.glyph_count);
         if (d[RSP_TDATA_W-1:RSP_USED_W] !== '0)
            report_mismatch("padding", d[RSP_TDATA_W-1:RSP_USED_W], 0);
      end
   endtask

   // Queues one frame. A negative size leaves out the size command; drop cuts
   // that many bytes off the end of the payload.
   task automatic add_frame(input int size, input int count, input int drop, input bit junk);
      int n;
      rx_q.push_back(HDR_BYTE);
      if (junk) begin
         rx_q.push_back(($urandom_range(1) == 0) ? CMD_UNUSED_A : CMD_UNUSED_B);
         rx_q.push_back(8'($urandom_range(8'hC0)));
         frame_items += 2;
      end
      if (size >= 0) begin
         rx_q.push_back(CMD_SIZE);
         rx_q.push_back(8'(size));
         frame_items += 2;
      end
      rx_q.push_back(CMD_COUNT);
      rx_q.push_back(8'(count));
      frame_items += 3;
      n = (count == 0) ? 0
          : int'(bytes_per_glyph((size < 0) ? SIZE_AUTO : 8'(size), 8'(count))) * count;
      n = (n > drop) ? n - drop : 0;
      for (int i = 0; i < n; i++) rx_q.push_back(8'($urandom_range(255)));
      frame_items += n;
   endtask

   task automatic add_random_frame();
      int r;
      r = $urandom_range(99);
      if (r < 48) add_frame(SIZE_SMALL, $urandom_range(1, 3), 0, $urandom_range(9) == 0);
      else if (r < 60) add_frame(SIZE_MID, 1, 0, $urandom_range(9) == 0);
      else if (r < 64) add_frame(SIZE_LARGE, 1, 0, 1'b0);
      else if (r < 70) begin
         case ($urandom_range(3))
            0: add_frame(-1, $urandom_range(1, 2), 0, 1'b0);
            1: add_frame(-1, 3, 0, 1'b0);
            2: add_frame(-1, 11, 0, 1'b0);
            default: add_frame(-1, 10, 0, 1'b1);
         endcase
      end else if (r < 76) add_frame($urandom_range(3), 0, 0, 1'b0);
      else if (r < 82) add_frame($urandom_range(4, 255), $urandom_range(255), 0, 1'b0);
      else if (r < 90) add_frame(SIZE_SMALL, 1, $urandom_range(1, 31), 1'b0);
      else begin
         // Noise between frames; the block echoes it like any other byte.
         repeat ($urandom_range(1, 6)) rx_q.push_back(8'($urandom_range(255)));
      end
   endtask

   task automatic wait_drained();
      while (rx_q.size() != 0 || req_tvalid || echo_q.size() != 0) @(posedge clock);
   endtask

   // Stimulus and end of run.
   initial begin
      // Idle bytes, unknown commands and a size above three.
      rx_q.push_back(8'h00);
      rx_q.push_back(8'hFF);
      rx_q.push_back(HDR_BYTE);
      rx_q.push_back(CMD_UNUSED_A);
      rx_q.push_back(CMD_UNUSED_B);
      rx_q.push_back(8'h00);
      add_frame(4, 7, 0, 1'b0);
      add_frame(-1, 0, 0, 1'b0);
      add_frame(SIZE_SMALL, 1, 0, 1'b0);
      add_frame(-1, 3, 0, 1'b0);
      add_frame(-1, 11, 0, 1'b0);
      add_frame(SIZE_MID, 1, 0, 1'b0);
      rx_q.push_back(8'h5A);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      frame_items = 0;
      calm_from   = req_beats + 300;
      while (frame_items < RANDOM_ITEMS / 2) add_random_frame();
      wait_drained();
      while (frame_items < RANDOM_ITEMS) add_random_frame();
      wait_drained();

      // Bring the parser back to idle, then open the largest frame.
      case (parse_ph)
         PH_DATA: begin
            repeat (int'(frame_total - frame_pos))
               rx_q.push_back(8'($urandom_range(255)));
         end
         PH_CMD: begin
            rx_q.push_back(CMD_COUNT);
            rx_q.push_back(8'h00);
         end
         PH_COUNT: rx_q.push_back(8'h00);
         PH_SIZE: begin
            rx_q.push_back(SIZE_AUTO);
            rx_q.push_back(CMD_COUNT);
            rx_q.push_back(8'h00);
         end
         default: begin
         end
      endcase
      wait_drained();
      add_frame(SIZE_LARGE, 255, LARGEST_DROP, 1'b0);
      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   // Sender.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (rx_q.size() != 0 && (no_idle || $urandom_range(99) >= 33)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= rx_q.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver, with one long hold-off while the sender keeps offering.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && req_beats >= 200) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 33);
      end
   end

   // Monitor on both channels.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            check_echo(rsp_tdata, rsp_tuser);
            rsp_beats <= rsp_beats + 1;
         end
         if (req_tvalid && req_tready) begin
            predict_echo(req_tdata);
            req_beats <= req_beats + 1;
         end
      end
   end

   // Watchdog: counts cycles without a beat while work is still pending.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (rx_q.size() == 0 && !req_tvalid && echo_q.size() == 0)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

FILE: glyph_frame_receiver.f
+incdir+rtl/core
rtl/core/gfr_pkg.sv
rtl/core/gfr_parser.sv
rtl/core/glyph_frame_receiver.sv
rtl/core/gfr_checker.sv
verif/tb_glyph_frame_receiver.sv
